// ===== sv/qga_pkg.sv =====
// ----------------------------------------------------------------------------
// qga_pkg
// Shared types, constants and helpers for the qubit gate amplitude update.
// ----------------------------------------------------------------------------
`default_nettype none

package qga_pkg;

  localparam int QUBITS  = 20;
  localparam int ADDR_W  = QUBITS;
  localparam int PAIR_W  = QUBITS - 1;
  localparam int AMP_W   = 16;
  localparam int COEF_W  = 18;
  localparam int QPOS_W  = 5;
  localparam int CIDX_W  = 3;
  localparam int PROD_W  = AMP_W + COEF_W;
  localparam int SUM_W   = PROD_W + 2;

  // 1/sqrt2 in Q1.16
  localparam logic signed [COEF_W-1:0] INV_SQRT2 = 18'sd46341;

  localparam logic signed [AMP_W-1:0] AMP_MAX = 16'sh7FFF;
  localparam logic signed [AMP_W-1:0] AMP_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    GK_RX = 2'd0,
    GK_H  = 2'd1,
    GK_CP = 2'd2
  } gate_kind_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_GATE_KIND = 3'd0,
    CFG_COS       = 3'd1,
    CFG_SIN       = 3'd2,
    CFG_TARGET    = 3'd3,
    CFG_SECOND    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    gate_kind_t               kind;
    logic signed [COEF_W-1:0] cos_c;
    logic signed [COEF_W-1:0] sin_c;
    logic [QPOS_W-1:0]        target;
    logic [QPOS_W-1:0]        second;
  } qga_cfg_t;

  typedef struct packed {
    logic signed [AMP_W-1:0] up_re;
    logic signed [AMP_W-1:0] up_im;
    logic signed [AMP_W-1:0] lo_re;
    logic signed [AMP_W-1:0] lo_im;
  } qga_amps_t;

  // Round a Q2.31 sum to Q1.15, halves up, then clamp.
  function automatic logic signed [AMP_W-1:0] round_sat(input logic signed [SUM_W-1:0] sum);
    logic signed [SUM_W-1:0]    biased;
    logic signed [SUM_W-17:0]   shifted;
    logic signed [AMP_W-1:0]    res;
    biased  = sum + SUM_W'(32768);
    shifted = biased[SUM_W-1:16];
    if (shifted > (SUM_W-16)'(AMP_MAX)) begin
      res = AMP_MAX;
    end else if (shifted < (SUM_W-16)'(AMP_MIN)) begin
      res = AMP_MIN;
    end else begin
      res = shifted[AMP_W-1:0];
    end
    return res;
  endfunction

  // Insert bit b at position pos, shifting the bits above it up by one.
  // A position past the top of the word leaves the word as it is.
  function automatic logic [ADDR_W-1:0] ins_bit(input logic [ADDR_W-1:0] v,
                                                input logic [QPOS_W-1:0] pos,
                                                input logic b);
    logic [ADDR_W-1:0] r;
    r = v;
    for (int i = 0; i < ADDR_W; i++) begin
      if (i < int'(pos)) begin
        r[i] = v[i];
      end else if (i == int'(pos)) begin
        r[i] = b;
      end else if (i > 0) begin
        r[i] = v[i-1];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/qga_butterfly.sv =====
// ----------------------------------------------------------------------------
// qga_butterfly
// Gate arithmetic for one amplitude pair: RX rotation, Hadamard, phase.
// ----------------------------------------------------------------------------
`default_nettype none

module qga_butterfly (
  input  var qga_pkg::qga_cfg_t  cfg,
  input  var qga_pkg::qga_amps_t amp_in,
  output qga_pkg::qga_amps_t     amp_out,
  output logic                   bad_setting
);
  import qga_pkg::*;

  logic signed [PROD_W-1:0] p_urc, p_urs, p_uic, p_uis;
  logic signed [PROD_W-1:0] p_lrc, p_lrs, p_lic, p_lis;
  logic signed [AMP_W:0]    h_sre, h_sim, h_dre, h_dim;
  logic signed [PROD_W:0]   h_p0, h_p1, h_p2, h_p3;
  logic                     cp_same;

  assign p_urc = amp_in.up_re * cfg.cos_c;
  assign p_urs = amp_in.up_re * cfg.sin_c;
  assign p_uic = amp_in.up_im * cfg.cos_c;
  assign p_uis = amp_in.up_im * cfg.sin_c;
  assign p_lrc = amp_in.lo_re * cfg.cos_c;
  assign p_lrs = amp_in.lo_re * cfg.sin_c;
  assign p_lic = amp_in.lo_im * cfg.cos_c;
  assign p_lis = amp_in.lo_im * cfg.sin_c;

  assign h_sre = (AMP_W+1)'(amp_in.up_re) + (AMP_W+1)'(amp_in.lo_re);
  assign h_sim = (AMP_W+1)'(amp_in.up_im) + (AMP_W+1)'(amp_in.lo_im);
  assign h_dre = (AMP_W+1)'(amp_in.up_re) - (AMP_W+1)'(amp_in.lo_re);
  assign h_dim = (AMP_W+1)'(amp_in.up_im) - (AMP_W+1)'(amp_in.lo_im);

  assign h_p0 = h_sre * INV_SQRT2;
  assign h_p1 = h_sim * INV_SQRT2;
  assign h_p2 = h_dre * INV_SQRT2;
  assign h_p3 = h_dim * INV_SQRT2;

  assign cp_same = (cfg.target == cfg.second);

  always_comb begin
    amp_out     = amp_in;
    bad_setting = 1'b0;
    case (cfg.kind)
      GK_RX: begin
        amp_out.up_re = round_sat(SUM_W'(p_urc) + SUM_W'(p_lis));
        amp_out.up_im = round_sat(SUM_W'(p_uic) - SUM_W'(p_lrs));
        amp_out.lo_re = round_sat(SUM_W'(p_uis) + SUM_W'(p_lrc));
        amp_out.lo_im = round_sat(SUM_W'(p_lic) - SUM_W'(p_urs));
      end
      GK_H: begin
        amp_out.up_re = round_sat(SUM_W'(h_p0));
        amp_out.up_im = round_sat(SUM_W'(h_p1));
        amp_out.lo_re = round_sat(SUM_W'(h_p2));
        amp_out.lo_im = round_sat(SUM_W'(h_p3));
      end
      GK_CP: begin
        // equal qubits: flag and pass everything through
        if (cp_same) begin
          bad_setting = 1'b1;
        end else begin
          amp_out.up_re = round_sat(SUM_W'(p_urc) - SUM_W'(p_uis));
          amp_out.up_im = round_sat(SUM_W'(p_urs) + SUM_W'(p_uic));
        end
      end
      default: begin
        amp_out = amp_in;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/qubit_gate_amplitude_update_top.sv =====
// ----------------------------------------------------------------------------
// qubit_gate_amplitude_update_top
// State-vector gate butterfly (single-qubit RX and H, two-qubit controlled phase) with address generation.
// ----------------------------------------------------------------------------
// An accepted beat passes the input register, then the result register;
// out_valid rises as the result register loads and holds for one cycle.
// Throughput: one beat per cycle; busy stays low, so start may be held high.
// The input register feeds one level of multiply, add, round and clamp into
// the result register.
// Reset (synchronous, rst_n low): config returns to its defaults and any
// beats in flight are dropped; the receiver cannot stall, so no backpressure.
`default_nettype none

module qubit_gate_amplitude_update_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [qga_pkg::PAIR_W-1:0]          in_pair_index,
  input  logic signed [qga_pkg::AMP_W-1:0]    in_up_re,
  input  logic signed [qga_pkg::AMP_W-1:0]    in_up_im,
  input  logic signed [qga_pkg::AMP_W-1:0]    in_lo_re,
  input  logic signed [qga_pkg::AMP_W-1:0]    in_lo_im,
  // result channel
  output logic                                out_valid,
  output logic [qga_pkg::ADDR_W-1:0]          out_up_addr,
  output logic [qga_pkg::ADDR_W-1:0]          out_lo_addr,
  output logic signed [qga_pkg::AMP_W-1:0]    out_new_up_re,
  output logic signed [qga_pkg::AMP_W-1:0]    out_new_up_im,
  output logic signed [qga_pkg::AMP_W-1:0]    out_new_lo_re,
  output logic signed [qga_pkg::AMP_W-1:0]    out_new_lo_im,
  output logic                                out_bad_setting,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [qga_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [qga_pkg::COEF_W-1:0]          cfg_wdata
);
  import qga_pkg::*;

  // configuration registers
  gate_kind_t               gate_kind_r;
  logic signed [COEF_W-1:0] cos_coeff_r;
  logic signed [COEF_W-1:0] sin_coeff_r;
  logic [QPOS_W-1:0]        target_qubit_r;
  logic [QPOS_W-1:0]        second_qubit_r;
  qga_cfg_t                 cfg;

  // input register
  logic                     in_v_r;
  logic [PAIR_W-1:0]        pair_r;
  qga_amps_t                amp_r;

  // datapath and address logic
  qga_amps_t                amp_nxt;
  logic                     bad_nxt;
  logic [ADDR_W-1:0]        up_addr_nxt;
  logic [ADDR_W-1:0]        lo_addr_nxt;
  logic [ADDR_W-1:0]        pair_ext;
  logic [ADDR_W-1:0]        cp_idx;
  logic [QPOS_W-1:0]        q_lo;
  logic [QPOS_W-1:0]        q_hi;
  logic [ADDR_W-1:0]        cp_addr;

  // result register
  logic                     out_valid_r;
  logic [ADDR_W-1:0]        up_addr_r;
  logic [ADDR_W-1:0]        lo_addr_r;
  qga_amps_t                amp_out_r;
  logic                     bad_r;

  logic                     accept;

  // Every cycle is open for a new beat.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration: writes land directly; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_kind_r    <= GK_RX;
      cos_coeff_r    <= 18'sd65536;
      sin_coeff_r    <= '0;
      target_qubit_r <= 5'd0;
      second_qubit_r <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GATE_KIND: gate_kind_r    <= gate_kind_t'(cfg_wdata[1:0]);
        CFG_COS:       cos_coeff_r    <= cfg_wdata;
        CFG_SIN:       sin_coeff_r    <= cfg_wdata;
        CFG_TARGET:    target_qubit_r <= cfg_wdata[QPOS_W-1:0];
        CFG_SECOND:    second_qubit_r <= cfg_wdata[QPOS_W-1:0];
        default:       ;
      endcase
    end
  end

  assign cfg.kind   = gate_kind_r;
  assign cfg.cos_c  = cos_coeff_r;
  assign cfg.sin_c  = sin_coeff_r;
  assign cfg.target = target_qubit_r;
  assign cfg.second = second_qubit_r;

  // Capture the beat; payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pair_r      <= in_pair_index;
      amp_r.up_re <= in_up_re;
      amp_r.up_im <= in_up_im;
      amp_r.lo_re <= in_lo_re;
      amp_r.lo_im <= in_lo_im;
    end
  end

  qga_butterfly u_bfly (
    .cfg         (cfg),
    .amp_in      (amp_r),
    .amp_out     (amp_nxt),
    .bad_setting (bad_nxt)
  );

  // Addresses. RX/H: insert a 0 (upper) or a 1 (lower) at the target bit.
  // CP: keep the low QUBITS-2 pair bits and insert 1s at the sorted qubit
  // positions, lower position first. Positions past the top leave the word.
  assign pair_ext = ADDR_W'(pair_r);
  assign cp_idx   = ADDR_W'(pair_r[QUBITS-3:0]);
  assign q_lo     = (target_qubit_r < second_qubit_r) ? target_qubit_r : second_qubit_r;
  assign q_hi     = (target_qubit_r < second_qubit_r) ? second_qubit_r : target_qubit_r;
  assign cp_addr  = ins_bit(ins_bit(cp_idx, q_lo, 1'b1), q_hi, 1'b1);

  always_comb begin
    if (gate_kind_r == GK_CP) begin
      up_addr_nxt = cp_addr;
      lo_addr_nxt = cp_addr;
    end else begin
      up_addr_nxt = ins_bit(pair_ext, target_qubit_r, 1'b0);
      lo_addr_nxt = ins_bit(pair_ext, target_qubit_r, 1'b1);
    end
  end

  // Result register: strobe for one cycle per beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_v_r) begin
      up_addr_r <= up_addr_nxt;
      lo_addr_r <= lo_addr_nxt;
      amp_out_r <= amp_nxt;
      bad_r     <= bad_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_up_addr     = up_addr_r;
  assign out_lo_addr     = lo_addr_r;
  assign out_new_up_re   = amp_out_r.up_re;
  assign out_new_up_im   = amp_out_r.up_im;
  assign out_new_lo_re   = amp_out_r.lo_re;
  assign out_new_lo_im   = amp_out_r.lo_im;
  assign out_bad_setting = bad_r;

`ifndef SYNTHESIS
  // A strobe only follows an accepted beat.
  a_strobe_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 2))
    else $error("result strobe without an accepted beat");

  // An accepted beat always comes out unless a reset falls in between.
  a_beat_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(rst_n, 2) && $past(accept, 2) |-> out_valid)
    else $error("accepted beat lost");

  // The flag only rises on a CP address, where both addresses coincide.
  a_bad_cp_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_setting |-> out_up_addr == out_lo_addr)
    else $error("bad_setting with distinct addresses");

  // In CP mode the upper and lower addresses are one and the same.
  a_cp_one_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (gate_kind_r == GK_CP) |-> out_up_addr == out_lo_addr)
    else $error("CP result with two addresses");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_qubit_gate_amplitude_update_top.sv =====
// ----------------------------------------------------------------------------
// tb_qubit_gate_amplitude_update_top
// Self-checking bench for the state-vector gate butterfly. Named tests load a
// gate setup over the write port, send amplitude pairs through the command
// channel and compare every result beat, field by field, against an in-bench
// fixed-point predictor of the RX, Hadamard and controlled-phase updates.
// ----------------------------------------------------------------------------
module tb_qubit_gate_amplitude_update_top;
  import qga_pkg::*;

  // Gate kind code with no gate behind it: amplitudes pass unchanged.
  localparam logic [1:0] GK_UNUSED = 2'd3;
  localparam int IDLE_PCT = 24;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 4;

  // Gate setup as held by the block's registers.
  typedef struct packed {
    logic [1:0]               kind;
    logic signed [COEF_W-1:0] cos_c;
    logic signed [COEF_W-1:0] sin_c;
    logic [QPOS_W-1:0]        target;
    logic [QPOS_W-1:0]        second;
  } gate_setup_t;

  // One result beat: both state addresses, new amplitudes and the flag.
  typedef struct packed {
    logic [ADDR_W-1:0] up_addr;
    logic [ADDR_W-1:0] lo_addr;
    qga_amps_t         amps;
    logic              bad;
  } amp_update_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [PAIR_W-1:0]        in_pair_index;
  logic signed [AMP_W-1:0]  in_up_re;
  logic signed [AMP_W-1:0]  in_up_im;
  logic signed [AMP_W-1:0]  in_lo_re;
  logic signed [AMP_W-1:0]  in_lo_im;
  logic                     out_valid;
  logic [ADDR_W-1:0]        out_up_addr;
  logic [ADDR_W-1:0]        out_lo_addr;
  logic signed [AMP_W-1:0]  out_new_up_re;
  logic signed [AMP_W-1:0]  out_new_up_im;
  logic signed [AMP_W-1:0]  out_new_lo_re;
  logic signed [AMP_W-1:0]  out_new_lo_im;
  logic                     out_bad_setting;
  logic                     cfg_we;
  logic [CIDX_W-1:0]        cfg_index;
  logic [COEF_W-1:0]        cfg_wdata;

  // Register shadow; starts at the reset defaults.
  gate_setup_t setup = '{GK_RX, 18'sd65536, 18'sd0, 5'd0, 5'd1};
  amp_update_t expected_updates[$];
  amp_update_t oldest;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          gaps_on = 1'b1;

  qubit_gate_amplitude_update_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_pair_index   (in_pair_index),
    .in_up_re        (in_up_re),
    .in_up_im        (in_up_im),
    .in_lo_re        (in_lo_re),
    .in_lo_im        (in_lo_im),
    .out_valid       (out_valid),
    .out_up_addr     (out_up_addr),
    .out_lo_addr     (out_lo_addr),
    .out_new_up_re   (out_new_up_re),
    .out_new_up_im   (out_new_up_im),
    .out_new_lo_re   (out_new_lo_re),
    .out_new_lo_im   (out_new_lo_im),
    .out_bad_setting (out_bad_setting),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Round a Q2.31 sum to Q1.15 with halves going up, then clamp.
  function automatic longint round_q15(input longint sum);
    longint r;
    r = (sum + 64'sd32768) >>> 16;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  // Open a 0 bit at pos; the bits from pos upward move up by one.
  function automatic longint unsigned open_bit_at(input longint unsigned v,
                                                  input int unsigned pos);
    return ((v >> pos) << (pos + 1)) | (v & ((64'd1 << pos) - 64'd1));
  endfunction

  function automatic longint unsigned set_bit_at(input longint unsigned v,
                                                 input int unsigned pos);
    return open_bit_at(v, pos) | (64'd1 << pos);
  endfunction

  // Work out the result beat for one pair under the current gate setup.
  function automatic amp_update_t gate_butterfly(input logic [PAIR_W-1:0] pair,
                                                 input qga_amps_t a);
    longint            ur, ui, lr, li, c, s, h;
    longint            nur, nui, nlr, nli;
    longint unsigned   idx, up, lo;
    int unsigned       t, q, lo_q, hi_q;
    logic              bad;
    amp_update_t       r;
    ur = a.up_re;
    ui = a.up_im;
    lr = a.lo_re;
    li = a.lo_im;
    c = setup.cos_c;
    s = setup.sin_c;
    h = INV_SQRT2;
    nur = ur;
    nui = ui;
    nlr = lr;
    nli = li;
    bad = 1'b0;
    t = setup.target;
    q = setup.second;
    if (setup.kind == GK_CP) begin
      lo_q = (t < q) ? t : q;
      hi_q = (t < q) ? q : t;
      idx = pair & ((64'd1 << (QUBITS - 2)) - 64'd1);
      up = set_bit_at(set_bit_at(idx, lo_q), hi_q);
      lo = up;
      if (t == q) begin
        bad = 1'b1;
      end else begin
        nur = round_q15(ur * c - ui * s);
        nui = round_q15(ur * s + ui * c);
      end
    end else begin
      idx = pair & ((64'd1 << (QUBITS - 1)) - 64'd1);
      up = open_bit_at(idx, t);
      lo = up + (64'd1 << t);
      if (setup.kind == GK_RX) begin
        nur = round_q15(ur * c + li * s);
        nui = round_q15(ui * c - lr * s);
        nlr = round_q15(ui * s + lr * c);
        nli = round_q15(li * c - ur * s);
      end else if (setup.kind == GK_H) begin
        nur = round_q15((ur + lr) * h);
        nui = round_q15((ui + li) * h);
        nlr = round_q15((ur - lr) * h);
        nli = round_q15((ui - li) * h);
      end
    end
    r.up_addr = up[ADDR_W-1:0];
    r.lo_addr = lo[ADDR_W-1:0];
    r.amps.up_re = nur[AMP_W-1:0];
    r.amps.up_im = nui[AMP_W-1:0];
    r.amps.lo_re = nlr[AMP_W-1:0];
    r.amps.lo_im = nli[AMP_W-1:0];
    r.bad = bad;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result check and watchdog
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare every strobed beat with the oldest expectation. Outputs are read
  // right after the edge, so they still hold the values of the ending cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_updates.size() == 0) begin
        $error("result beat with no pending pair: up_addr %0h", out_up_addr);
        mismatches++;
      end else begin
        oldest = expected_updates.pop_front();
        check_field("up_addr", oldest.up_addr, out_up_addr);
        check_field("lo_addr", oldest.lo_addr, out_lo_addr);
        check_field("new_up_re", oldest.amps.up_re, out_new_up_re);
        check_field("new_up_im", oldest.amps.up_im, out_new_up_im);
        check_field("new_lo_re", oldest.amps.lo_re, out_new_lo_re);
        check_field("new_lo_im", oldest.amps.lo_im, out_new_lo_im);
        check_field("bad_setting", oldest.bad, out_bad_setting);
      end
    end
  end

  // Count cycles where no beat moves on either side; give up past the limit.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Hold start with the pair until the block takes it, record the expected
  // beat, then maybe drop start and idle. Leave start high when not idling so
  // a following beat goes out back to back.
  task automatic push_pair(input logic [PAIR_W-1:0] pair, input qga_amps_t amps);
    start <= 1'b1;
    in_pair_index <= pair;
    in_up_re <= amps.up_re;
    in_up_im <= amps.up_im;
    in_lo_re <= amps.lo_re;
    in_lo_im <= amps.lo_im;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_updates = {expected_updates, gate_butterfly(pair, amps)};
    if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  // Drop start and wait until every pending beat has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_updates.size() != 0) @(posedge clk);
  endtask

  // Raise the write enable for one edge; the caller lowers it afterwards.
  task automatic write_reg(input cfg_idx_t idx, input logic [COEF_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Write all five registers back to back while the block is idle.
  task automatic load_gate(input logic [1:0] kind, input int cos_v, input int sin_v,
                           input int tq, input int sq);
    write_reg(CFG_GATE_KIND, COEF_W'(kind));
    write_reg(CFG_COS, COEF_W'(cos_v));
    write_reg(CFG_SIN, COEF_W'(sin_v));
    write_reg(CFG_TARGET, COEF_W'(tq));
    write_reg(CFG_SECOND, COEF_W'(sq));
    cfg_we <= 1'b0;
    setup.kind = kind;
    setup.cos_c = COEF_W'(cos_v);
    setup.sin_c = COEF_W'(sin_v);
    setup.target = QPOS_W'(tq);
    setup.second = QPOS_W'(sq);
  endtask

  // Full-scale pairs: everything at the top, everything at the bottom, mixed.
  task automatic send_corners();
    push_pair({PAIR_W{1'b1}}, '{AMP_MAX, AMP_MAX, AMP_MAX, AMP_MAX});
    push_pair('0, '{AMP_MIN, AMP_MIN, AMP_MIN, AMP_MIN});
    push_pair(PAIR_W'($urandom), '{AMP_MAX, AMP_MIN, AMP_MIN, AMP_MAX});
  endtask

  function automatic logic signed [AMP_W-1:0] pick_amp();
    case ($urandom_range(15))
      0: return AMP_MAX;
      1: return AMP_MIN;
      2: return '0;
      default: return AMP_W'($urandom);
    endcase
  endfunction

  // Mostly in-range coefficients, some at the rails, some over the full port.
  function automatic int pick_coeff();
    case ($urandom_range(19))
      0: return 65536;
      1: return -65536;
      2: return 0;
      3, 4: return int'($urandom_range(262143)) - 131072;
      default: return int'($urandom_range(131072)) - 65536;
    endcase
  endfunction

  function automatic int pick_qubit();
    if ($urandom_range(9) == 0) return int'($urandom_range(31));
    return int'($urandom_range(QUBITS - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults: RX with cos = 1, sin = 0 on target 0, so identity.
  task automatic test_reset_defaults();
    send_corners();
    drain_results();
  endtask

  // RX with cos = 1/sqrt2 and sin = -1/sqrt2 on the top target; some results of full-scale inputs saturate.
  task automatic test_rx_rotation();
    load_gate(GK_RX, 46341, -46341, QUBITS - 1, 0);
    send_corners();
    drain_results();
  endtask

  task automatic test_hadamard();
    load_gate(GK_H, 0, 0, 10, 3);
    send_corners();
    drain_results();
  endtask

  // Controlled phase with the qubits given in falling order, then with equal
  // positions, which must raise the flag and pass amplitudes through.
  task automatic test_controlled_phase();
    load_gate(GK_CP, 0, 65536, QUBITS - 1, 0);
    send_corners();
    drain_results();
    load_gate(GK_CP, -65536, 65536, 5, 5);
    send_corners();
    drain_results();
  endtask

  // Unused kind, qubit positions past the top of the address, and
  // coefficients beyond +-1 on the full port range.
  task automatic test_odd_settings();
    load_gate(GK_UNUSED, 131071, -131072, 31, 20);
    send_corners();
    drain_results();
    load_gate(GK_CP, -131072, 131071, 25, 31);
    send_corners();
    drain_results();
    load_gate(GK_RX, -131072, 131071, QUBITS, 2);
    send_corners();
    drain_results();
  endtask

  // Random phases: a fresh setup each, cycling the gate kinds. The first
  // phase runs with no idling at all.
  task automatic test_random_gates();
    logic [1:0] kind;
    int         tq;
    int         sq;
    int         n;
    for (int ph = 0; ph < 30; ph++) begin
      if (ph % 10 == 9) begin
        kind = GK_UNUSED;
      end else begin
        case (ph % 3)
          0: kind = GK_RX;
          1: kind = GK_H;
          default: kind = GK_CP;
        endcase
      end
      tq = pick_qubit();
      sq = ($urandom_range(7) == 0) ? tq : pick_qubit();
      load_gate(kind, pick_coeff(), pick_coeff(), tq, sq);
      gaps_on = (ph != 0);
      n = (ph == 0) ? 200 : 52;
      for (int i = 0; i < n; i++) begin
        push_pair(PAIR_W'($urandom), '{pick_amp(), pick_amp(), pick_amp(), pick_amp()});
      end
      drain_results();
    end
  endtask

  initial begin
    // Hold every input at a known value from time zero.
    rst_n <= 1'b0;
    start <= 1'b0;
    in_pair_index <= '0;
    in_up_re <= '0;
    in_up_im <= '0;
    in_lo_re <= '0;
    in_lo_im <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_GATE_KIND;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_rx_rotation();
    test_hadamard();
    test_controlled_phase();
    test_odd_settings();
    test_random_gates();

    // Let any stray beat surface past the pipeline depth before judging.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_updates.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
